>>> src/sot_pkg.sv
// Shared types and codes for the stacking order table.
// Holds request and response payloads, controller commands and datapath status.
// No dependencies.
package sot_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int ID_BITS_DEF  = 8;

   localparam int KIND_W   = 3;
   localparam int ID_W     = 8;
   localparam int DEPTH_W  = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TOP    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UP     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DOWN   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_BOTTOM = 3'd5;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd6;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_DONE   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUP    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DEPTH  = 3'd4;

   // Source of the entry that moves.
   localparam logic FROM_POS   = 1'b0;
   localparam logic FROM_COUNT = 1'b1;

   // Destination of the entry that moves.
   localparam logic [1:0] TO_ZERO  = 2'd0;
   localparam logic [1:0] TO_LAST  = 2'd1;
   localparam logic [1:0] TO_ABOVE = 2'd2;
   localparam logic [1:0] TO_BELOW = 2'd3;

   // Address of the shared slot read port.
   localparam logic RD_DEPTH = 1'b0;
   localparam logic RD_LAST  = 1'b1;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    object_id;
      logic [DEPTH_W-1:0] depth;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
      logic [ID_W-1:0]     top_id;
      logic [ID_W-1:0]     bottom_id;
      logic [ID_W-1:0]     read_id;
   } rsp_type;

   typedef struct packed {
      logic                capture;
      logic                look;
      logic                move_en;
      logic                from_sel;
      logic [1:0]          to_sel;
      logic                count_inc;
      logic                count_dec;
      logic                rd_sel;
      logic                read_keep;
      logic                rsp_load;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              found;
      logic              at_top;
      logic              at_bottom;
      logic              full;
      logic              depth_ok;
   } stat_type;

endpackage

>>> src/stacking_order_table.sv
// Top level of the stacking order table.
// Depends on sot_pkg, sot_ctrl and sot_dpath.
//
// Keeps up to CAPACITY distinct ids in stacking order, slot 0 on top, and
// answers every request with one response: status, entry count, top and
// bottom ids and, for a read, the id at the requested depth. A request passes
// through the sequencer in four steps: capture at acceptance, a compare
// of the id against every slot at once, one shift of the whole slot row, and
// the response load, which reads the new bottom through the single slot read
// port once the previous response, if any, has been taken.
// The sequencer handles one request at a time; a finished response sits in its
// own register, so the next request is accepted while it waits to be taken,
// and only the load of the following response waits for it.
module stacking_order_table #(
   parameter int CAPACITY = sot_pkg::CAPACITY_DEF,
   parameter int ID_BITS  = sot_pkg::ID_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sot_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sot_pkg::rsp_type rsp_data
);
   import sot_pkg::*;

   localparam logic [COUNT_W-1:0] CAP_CODE = COUNT_W'(CAPACITY);

   cmd_type  cmd;
   stat_type stat;

   sot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sot_dpath #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // The sequencer takes no second request while one is in flight.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the previous one was in flight");

   // A refused add to a full table must report the full count.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FULL) |-> rsp_data.entry_count == CAP_CODE)
      else $error("table full reported with a count below capacity");

   // An empty table reports zero ids.
   a_empty_ids: assert property (@(posedge clock) disable iff (reset)
      (CAPACITY < 32) && rsp_valid && (rsp_data.entry_count == '0)
      |-> (rsp_data.top_id == '0) && (rsp_data.bottom_id == '0))
      else $error("empty table reported a nonzero top or bottom id");

endmodule

>>> src/sot_dpath.sv
// Datapath of the stacking order table: slot row, id compare, shift and response register.
// Depends on sot_pkg; driven by sot_ctrl through cmd_type.
module sot_dpath #(
   parameter int CAPACITY = sot_pkg::CAPACITY_DEF,
   parameter int ID_BITS  = sot_pkg::ID_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  sot_pkg::req_type  req_data,
   input  sot_pkg::cmd_type  cmd,
   output sot_pkg::stat_type stat,
   output sot_pkg::rsp_type  rsp_data
);
   import sot_pkg::*;

   localparam int IDX_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int IDW      = ID_BITS + ID_W;
   localparam int DIW      = IDX_BITS + DEPTH_W;
   localparam int CMPW     = CNT_BITS + DEPTH_W;
   localparam int CNTW     = CNT_BITS + COUNT_W;

   logic [KIND_W-1:0]   kind_ff;
   logic [ID_BITS-1:0]  id_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [ID_BITS-1:0]  slot_ff [CAPACITY];
   logic [ID_BITS-1:0]  slot_in [CAPACITY];
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic [IDX_BITS-1:0] pos_ff;
   logic [ID_BITS-1:0]  read_ff;
   rsp_type             rsp_ff;

   logic [IDW-1:0]      id_wide;
   logic [CAPACITY-1:0] match;
   logic [CAPACITY-1:0] last;
   logic [IDX_BITS-1:0] pos_enc;
   logic [CNT_BITS-1:0] cnt_m1;
   logic [DIW-1:0]      depth_wide;
   logic [IDX_BITS-1:0] rd_idx;
   logic [ID_BITS-1:0]  rd_data;
   logic [IDX_BITS-1:0] from_idx;
   logic [IDX_BITS-1:0] to_idx;
   logic [CNTW-1:0]     count_wide;
   logic [IDW-1:0]      top_wide;
   logic [IDW-1:0]      bot_wide;
   logic [IDW-1:0]      read_wide;

   assign id_wide    = IDW'(req_data.object_id);
   assign cnt_m1     = count_ff - CNT_BITS'(1);
   assign depth_wide = DIW'(depth_ff);

   // Ids are distinct, so at most one live slot matches and an OR encodes it.
   always_comb begin
      pos_enc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = (CNT_BITS'(i) < count_ff) && (slot_ff[i] == id_ff);
         last[i]  = (CNT_BITS'(i) == cnt_m1);
         if (match[i]) begin
            pos_enc = pos_enc | IDX_BITS'(i);
         end
      end
   end

   assign stat.kind      = kind_ff;
   assign stat.found     = |match;
   assign stat.at_top    = match[0];
   assign stat.at_bottom = |(match & last);
   assign stat.full      = (count_ff == CNT_BITS'(CAPACITY));
   assign stat.depth_ok  = (CMPW'(depth_ff) < CMPW'(count_ff));

   assign rd_idx  = (cmd.rd_sel == RD_DEPTH) ? depth_wide[IDX_BITS-1:0] : cnt_m1[IDX_BITS-1:0];
   assign rd_data = slot_ff[rd_idx];

   always_comb begin
      from_idx = (cmd.from_sel == FROM_COUNT) ? count_ff[IDX_BITS-1:0] : pos_ff;
      case (cmd.to_sel)
         TO_ZERO:  to_idx = '0;
         TO_LAST:  to_idx = cnt_m1[IDX_BITS-1:0];
         TO_ABOVE: to_idx = pos_ff - IDX_BITS'(1);
         TO_BELOW: to_idx = pos_ff + IDX_BITS'(1);
         default:  to_idx = '0;
      endcase
   end

   // Relocation: the moving id lands at the destination and the slots between
   // shift one place toward the vacated source.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         slot_in[i] = slot_ff[i];
         if (cmd.move_en) begin
            if (IDX_BITS'(i) == to_idx) begin
               slot_in[i] = id_ff;
            end else if ((from_idx > to_idx) && (IDX_BITS'(i) > to_idx) &&
                         (IDX_BITS'(i) <= from_idx)) begin
               slot_in[i] = slot_ff[(i == 0) ? 0 : i - 1];
            end else if ((to_idx > from_idx) && (IDX_BITS'(i) >= from_idx) &&
                         (IDX_BITS'(i) < to_idx)) begin
               slot_in[i] = slot_ff[(i == CAPACITY - 1) ? i : i + 1];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.count_dec) begin
         count_in = cnt_m1;
      end
   end

   assign count_wide = CNTW'(count_ff);
   assign top_wide   = IDW'(slot_ff[0]);
   assign bot_wide   = IDW'(rd_data);
   assign read_wide  = IDW'(read_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (cmd.capture) begin
         kind_ff  <= req_data.kind;
         id_ff    <= id_wide[ID_BITS-1:0];
         depth_ff <= req_data.depth;
      end
      if (cmd.look) begin
         pos_ff  <= pos_enc;
         read_ff <= cmd.read_keep ? rd_data : '0;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status      <= cmd.status;
         rsp_ff.entry_count <= count_wide[COUNT_W-1:0];
         rsp_ff.top_id      <= (count_ff != '0) ? top_wide[ID_W-1:0] : '0;
         rsp_ff.bottom_id   <= (count_ff != '0) ? bot_wide[ID_W-1:0] : '0;
         rsp_ff.read_id     <= read_wide[ID_W-1:0];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> src/sot_ctrl.sv
// Controller of the stacking order table: request sequencer and response valid.
// Depends on sot_pkg; commands sot_dpath through cmd_type, reads stat_type.
module sot_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  sot_pkg::stat_type stat,
   output sot_pkg::cmd_type  cmd
);
   import sot_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_MOVE = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   typedef struct packed {
      logic       move_en;
      logic       from_sel;
      logic [1:0] to_sel;
      logic       count_inc;
      logic       count_dec;
   } plan_type;

   logic [1:0]          state_ff;
   logic [1:0]          state_in;
   plan_type            plan_ff;
   plan_type            plan_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                absent;

   // Decode of the compare results into a move plan and a status.
   always_comb begin
      plan_in   = '0;
      status_in = ST_DONE;
      absent    = !stat.found && (stat.kind inside {[KIND_REMOVE:KIND_BOTTOM]});
      case (stat.kind)
         KIND_ADD: begin
            if (stat.found) begin
               status_in = ST_DUP;
            end else if (stat.full) begin
               status_in = ST_FULL;
            end else begin
               plan_in.move_en   = 1'b1;
               plan_in.from_sel  = FROM_COUNT;
               plan_in.to_sel    = TO_ZERO;
               plan_in.count_inc = 1'b1;
            end
         end
         KIND_REMOVE: begin
            plan_in.move_en   = 1'b1;
            plan_in.to_sel    = TO_LAST;
            plan_in.count_dec = 1'b1;
         end
         KIND_TOP: begin
            plan_in.move_en = 1'b1;
            plan_in.to_sel  = TO_ZERO;
         end
         KIND_UP: begin
            plan_in.move_en = !stat.at_top;
            plan_in.to_sel  = TO_ABOVE;
         end
         KIND_DOWN: begin
            plan_in.move_en = !stat.at_bottom;
            plan_in.to_sel  = TO_BELOW;
         end
         KIND_BOTTOM: begin
            plan_in.move_en = 1'b1;
            plan_in.to_sel  = TO_LAST;
         end
         KIND_READ: begin
            if (!stat.depth_ok) begin
               status_in = ST_DEPTH;
            end
         end
         default: begin
         end
      endcase
      if (absent) begin
         plan_in   = '0;
         status_in = ST_ABSENT;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.status = status_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look      = 1'b1;
            cmd.rd_sel    = RD_DEPTH;
            cmd.read_keep = (stat.kind == KIND_READ) && stat.depth_ok;
            state_in      = S_MOVE;
         end
         S_MOVE: begin
            cmd.move_en   = plan_ff.move_en;
            cmd.from_sel  = plan_ff.from_sel;
            cmd.to_sel    = plan_ff.to_sel;
            cmd.count_inc = plan_ff.count_inc;
            cmd.count_dec = plan_ff.count_dec;
            state_in      = S_FIN;
         end
         S_FIN: begin
            cmd.rd_sel = RD_LAST;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOOK) begin
         plan_ff   <= plan_in;
         status_ff <= status_in;
      end
   end

endmodule

>>> test/tb_stacking_order_table.sv
`timescale 1ns / 100ps
// Testbench for stacking_order_table: sends requests over valid/ready and checks every
// response against an in-bench model of the stacking order. Depends on sot_pkg and the RTL.
module tb_stacking_order_table;
   import sot_pkg::*;

   localparam int SLOTS = CAPACITY_DEF;
   localparam int STALL_PCT = 27;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_REQUESTS = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

   // Mirrors the stacking order and queues the response each request should produce.
   class order_scoreboard;
      logic [ID_W-1:0] slots [SLOTS];
      int held;
      int errors;
      rsp_type expected_q [$];

      function new();
         held = 0;
         errors = 0;
      endfunction

      function void shift_entry(int from, int to);
         logic [ID_W-1:0] moved;
         moved = slots[from];
         if (from > to) begin
            for (int i = from; i > to; i--) slots[i] = slots[i-1];
         end else begin
            for (int i = from; i < to; i++) slots[i] = slots[i+1];
         end
         slots[to] = moved;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int pos;
         e = '0;
         e.status = ST_DONE;
         pos = held;
         for (int i = 0; i < held; i++) begin
            if (slots[i] == r.object_id) pos = i;
         end
         if (r.kind == KIND_ADD) begin
            // A duplicate is reported even when the table is also full.
            if (pos < held) e.status = ST_DUP;
            else if (held >= SLOTS) e.status = ST_FULL;
            else begin
               slots[held] = r.object_id;
               held++;
               shift_entry(held - 1, 0);
            end
         end else if (r.kind == KIND_READ) begin
            if (r.depth < held) e.read_id = slots[r.depth];
            else e.status = ST_DEPTH;
         end else if (r.kind != KIND_UNUSED) begin
            if (pos == held) e.status = ST_ABSENT;
            else begin
               case (r.kind)
                  KIND_REMOVE: begin
                     shift_entry(pos, held - 1);
                     held--;
                  end
                  KIND_TOP: shift_entry(pos, 0);
                  KIND_UP: if (pos > 0) shift_entry(pos, pos - 1);
                  KIND_DOWN: if (pos + 1 < held) shift_entry(pos, pos + 1);
                  default: shift_entry(pos, held - 1);
               endcase
            end
         end
         e.entry_count = COUNT_W'(held);
         if (held > 0) begin
            e.top_id = slots[0];
            e.bottom_id = slots[held - 1];
         end
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
         compare_field("top_id", 32'(want.top_id), 32'(got.top_id));
         compare_field("bottom_id", 32'(want.bottom_id), 32'(got.bottom_id));
         compare_field("read_id", 32'(want.read_id), 32'(got.read_id));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic steady;
   int idle_cycles;
   order_scoreboard sb;

   stacking_order_table dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= STALL_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // Ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type pack_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                            logic [DEPTH_W-1:0] depth);
      req_type r;
      r.kind = kind;
      r.object_id = id;
      r.depth = depth;
      return r;
   endfunction

   // Mostly targets ids that are held, so moves and removes do real work.
   function automatic req_type random_request(bit grow);
      req_type r;
      int roll;
      roll = $urandom_range(99);
      r.depth = DEPTH_W'($urandom_range(15));
      if (roll < (grow ? 45 : 10)) r.kind = KIND_ADD;
      else if (roll < 55) r.kind = KIND_REMOVE;
      else if (roll < 96) r.kind = KIND_W'($urandom_range(KIND_READ, KIND_TOP));
      else r.kind = KIND_UNUSED;
      if (sb.held > 0 && $urandom_range(99) < (r.kind == KIND_ADD ? 15 : 80))
         r.object_id = sb.slots[$urandom_range(sb.held - 1)];
      else
         r.object_id = ID_W'($urandom_range(255));
      return r;
   endfunction

   task automatic send_request(req_type r);
      int gap;
      gap = (!steady && $urandom_range(99) < STALL_PCT) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      bit grow;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      steady = 1'b0;
      idle_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table cases, then the end-of-order moves on a small table.
      send_request(pack_request(KIND_READ, 8'h00, 4'd0));
      send_request(pack_request(KIND_REMOVE, 8'h05, 4'd0));
      send_request(pack_request(KIND_UNUSED, 8'hFF, 4'd15));
      send_request(pack_request(KIND_ADD, 8'h00, 4'd0));
      send_request(pack_request(KIND_ADD, 8'hFF, 4'd0));
      send_request(pack_request(KIND_ADD, 8'h00, 4'd0));
      send_request(pack_request(KIND_UP, 8'hFF, 4'd0));
      send_request(pack_request(KIND_TOP, 8'hFF, 4'd0));
      send_request(pack_request(KIND_DOWN, 8'h00, 4'd0));
      send_request(pack_request(KIND_BOTTOM, 8'h00, 4'd0));
      send_request(pack_request(KIND_ADD, 8'hA5, 4'd0));
      send_request(pack_request(KIND_UP, 8'h00, 4'd0));
      send_request(pack_request(KIND_DOWN, 8'hA5, 4'd0));
      send_request(pack_request(KIND_BOTTOM, 8'hFF, 4'd0));
      send_request(pack_request(KIND_TOP, 8'h00, 4'd0));
      send_request(pack_request(KIND_READ, 8'h00, 4'd1));
      send_request(pack_request(KIND_READ, 8'h00, 4'd15));
      send_request(pack_request(KIND_REMOVE, 8'hA5, 4'd0));
      send_request(pack_request(KIND_REMOVE, 8'h5A, 4'd0));
      send_request(pack_request(KIND_UP, 8'h33, 4'd0));
      send_request(pack_request(KIND_UNUSED, 8'h00, 4'd0));
      drain_responses();

      // Alternate filling and draining so the table swings between empty and full.
      grow = 1'b1;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         steady = (n >= 600 && n < 900);
         if (n == RANDOM_REQUESTS / 2) drain_responses();
         if (grow && sb.held == SLOTS && $urandom_range(7) == 0) grow = 1'b0;
         else if (!grow && sb.held == 0) grow = 1'b1;
         send_request(random_request(grow));
      end
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
